>>> hdl/phls_pkg.sv
// Package for the per-host limited job scheduler.
// Holds table sizes, result kinds and the controller/datapath command and status structs.
package phls_pkg;

  localparam int PendingDepth = 16;
  localparam int NumHosts     = 32;
  localparam int NumJobs      = 64;
  localparam int PendW        = $clog2(PendingDepth);
  localparam int HostW        = $clog2(NumHosts);
  localparam int JobW         = 6;
  localparam int CntW         = 7;
  localparam logic [1:0] MaxBackoffExp = 2'd3;

  typedef enum logic [2:0] {
    K_QUEUED    = 3'd0,
    K_STARTED   = 3'd1,
    K_DONE_OK   = 3'd2,
    K_DONE_FAIL = 3'd3,
    K_RETRY     = 3'd4,
    K_FULL      = 3'd5,
    K_UNKNOWN   = 3'd6
  } kind_t;

  localparam logic CFG_GLOBAL_LIMIT = 1'b0;

  typedef struct packed {
    logic load;       // latch input request and read its job record
    logic exec;       // do the event work of the latched request
    logic scan_start; // clear scan index
    logic scan_step;  // advance scan index
    logic take;       // start the job at scan index
    logic emit_event; // load output with event result
    logic emit_start; // load output with start result
  } cmd_t;

  typedef struct packed {
    logic scan_can;   // global check and pending present
    logic scan_hit;   // entry at scan index is startable
    logic scan_end;   // scan index at last used entry
  } stat_t;

endpackage

>>> hdl/per_host_limited_job_scheduler.sv
// Top level of the per-host limited job scheduler.
// Depends on phls_pkg, phls_ctrl and phls_datapath.
// Use:
//   s_axis carries requests: op (add 0 / complete 1), job id, host id,
//   retry budget and success flag. m_axis returns one result for the add
//   or completion, then a second "started" result when a pending job was
//   started; tlast marks the final result of a request.
//   The cfg channel writes global_limit (index 0) and host_limit (index 1);
//   write only while no request is in flight.
// Sequence:
//   One request at a time. After acceptance: event work, a check, then a
//   scan of up to 16 pending entries (one pending entry per cycle) that
//   stops at the first startable entry, then the output register is loaded.
// Reset:
//   rst clears counters and active flags, limits return to 4 and 2.
// Stall:
//   A stalled m_axis holds the result stable; s_axis_tready stays low
//   until all results of the current request are taken.
module per_host_limited_job_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // op, job_id[6], host_id[5], retries_left[2], success
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // kind[3], job_id_out[6], host_id_out[5], delay_seconds[4],
                                     // all_idle
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import phls_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [CntW-1:0] global_limit;
  logic [CntW-1:0] host_limit;
  logic [2:0] o_kind;
  logic [5:0] o_job;
  logic [4:0] o_host;
  logic [3:0] o_delay;
  logic       o_idle;
  logic       busy;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      global_limit <= 7'd4;
      host_limit   <= 7'd2;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_GLOBAL_LIMIT) global_limit <= cfg_data;
      else host_limit <= cfg_data;
    end
  end

  phls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_last  (m_axis_tlast),
    .hold_busy (busy),
    .cmd       (cmd),
    .stat      (stat)
  );

  phls_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (s_axis_tdata[0]),
    .in_job        (s_axis_tdata[6:1]),
    .in_host       (s_axis_tdata[11:7]),
    .in_retries    (s_axis_tdata[13:12]),
    .in_ok         (s_axis_tdata[14]),
    .global_limit  (global_limit),
    .host_limit    (host_limit),
    .out_take_last (1'b0 & busy),
    .out_kind      (o_kind),
    .out_job       (o_job),
    .out_host      (o_host),
    .out_delay     (o_delay),
    .out_idle      (o_idle)
  );

  assign m_axis_tdata = {5'd0, o_idle, o_delay, o_host, o_job, o_kind};

endmodule

>>> hdl/phls_datapath.sv
// Datapath of the job scheduler: pending table, job tables, counters, output register.
// Depends on phls_pkg.
module phls_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  phls_pkg::cmd_t             cmd,
  output phls_pkg::stat_t            stat,
  input  logic                       in_op,
  input  logic [5:0]                 in_job,
  input  logic [4:0]                 in_host,
  input  logic [1:0]                 in_retries,
  input  logic                       in_ok,
  input  logic [phls_pkg::CntW-1:0]  global_limit,
  input  logic [phls_pkg::CntW-1:0]  host_limit,
  input  logic                       out_take_last,
  output logic [2:0]                 out_kind,
  output logic [5:0]                 out_job,
  output logic [4:0]                 out_host,
  output logic [3:0]                 out_delay,
  output logic                       out_idle
);
  import phls_pkg::*;

  logic [JobW-1:0]  pend_job  [PendingDepth];
  logic [HostW-1:0] pend_host [PendingDepth];
  logic [1:0]       pend_ret  [PendingDepth];
  logic [PendW:0]   pend_used;
  logic [CntW-1:0]  active_total;
  logic [CntW-1:0]  host_active [NumHosts];
  logic [NumJobs-1:0] job_active;
  logic [HostW-1:0] job_host [NumJobs];
  logic [1:0]       job_ret  [NumJobs];
  logic [PendW-1:0] idx;
  logic [PendW-1:0] last_idx;

  logic             req_op;
  logic [JobW-1:0]  req_job;
  logic [HostW-1:0] req_host;
  logic [1:0]       req_ret;
  logic             req_ok;
  logic             in_range;
  logic [HostW-1:0] cur_host;
  logic [1:0]       cur_ret;
  logic             is_act;
  logic             can_add;
  logic [HostW-1:0] sel_host;
  logic [5:0]       job_id_started;
  logic [4:0]       start_host;

  assign in_range = ({1'b0, req_job} < 7'(NumJobs));
  assign is_act   = in_range && job_active[req_job];
  assign can_add  = (pend_used < (PendW+1)'(PendingDepth));
  assign sel_host = pend_host[idx];
  assign last_idx = PendW'(pend_used - 1'b1);

  assign stat.scan_can = (pend_used != '0) && (active_total < global_limit);
  assign stat.scan_hit = host_active[sel_host] < host_limit;
  assign stat.scan_end = (idx == last_idx);

  // latch the request and read the job record at its id
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= in_op;
      req_job  <= in_job;
      req_host <= in_host;
      req_ret  <= in_retries;
      req_ok   <= in_ok;
      cur_host <= job_host[in_job];
      cur_ret  <= job_ret[in_job];
    end
  end

  // pending table and job tables: no reset
  always_ff @(posedge clk) begin
    if (cmd.exec && in_range && !req_op && can_add) begin
      pend_job[pend_used[PendW-1:0]]  <= req_job;
      pend_host[pend_used[PendW-1:0]] <= req_host;
      pend_ret[pend_used[PendW-1:0]]  <= req_ret;
    end
    if (cmd.exec && is_act && req_op && !req_ok && cur_ret != 2'd0)
      job_ret[req_job] <= cur_ret - 2'd1;
    if (cmd.take) begin
      pend_job[idx]  <= pend_job[last_idx];
      pend_host[idx] <= pend_host[last_idx];
      pend_ret[idx]  <= pend_ret[last_idx];
      job_host[pend_job[idx]] <= sel_host;
      job_ret[pend_job[idx]]  <= pend_ret[idx];
    end
  end

  // counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_used    <= '0;
      active_total <= '0;
      job_active   <= '0;
      for (int h = 0; h < NumHosts; h++) host_active[h] <= '0;
    end else begin
      if (cmd.exec && in_range && !req_op && can_add)
        pend_used <= pend_used + 1'b1;
      if (cmd.exec && req_op && is_act) begin
        job_active[req_job] <= 1'b0;
        if (active_total != '0) active_total <= active_total - 1'b1;
        if (host_active[cur_host] != '0)
          host_active[cur_host] <= host_active[cur_host] - 1'b1;
      end
      if (cmd.take) begin
        pend_used <= pend_used - 1'b1;
        active_total <= active_total + 1'b1;
        host_active[sel_host] <= host_active[sel_host] + 1'b1;
        job_active[pend_job[idx]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) idx <= '0;
    else if (cmd.scan_step) idx <= idx + 1'b1;
  end

  // event result computed during event work, held until emitted
  logic [2:0] ev_kind;
  logic [4:0] ev_host;
  logic [3:0] ev_delay;
  logic [5:0] ev_job;
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ev_job   <= req_job;
      ev_delay <= '0;
      ev_host  <= '0;
      if (!in_range) ev_kind <= K_UNKNOWN;
      else if (!req_op) begin
        ev_host <= req_host;
        ev_kind <= can_add ? K_QUEUED : K_FULL;
      end else if (!is_act) ev_kind <= K_UNKNOWN;
      else begin
        ev_host <= cur_host;
        if (!req_ok && cur_ret != 2'd0) begin
          ev_kind  <= K_RETRY;
          ev_delay <= 4'(1) << (MaxBackoffExp - (cur_ret - 2'd1));
        end else ev_kind <= req_ok ? K_DONE_OK : K_DONE_FAIL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_event) begin
      out_kind  <= ev_kind;
      out_job   <= ev_job;
      out_host  <= ev_host;
      out_delay <= ev_delay;
    end else if (cmd.emit_start) begin
      out_kind  <= K_STARTED;
      out_job   <= job_id_started;
      out_host  <= start_host;
      out_delay <= '0;
    end
    if (cmd.emit_event || cmd.emit_start)
      out_idle <= (pend_used == '0) && (active_total == '0) && !out_take_last;
  end

  // remember started job for its result
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      job_id_started <= pend_job[idx];
      start_host     <= sel_host;
    end
  end

endmodule

>>> hdl/phls_ctrl.sv
// Controller of the job scheduler: sequences event, pending scan and result hand-off.
// Depends on phls_pkg.
module phls_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_last,
  output logic             hold_busy,
  output phls_pkg::cmd_t   cmd,
  input  phls_pkg::stat_t  stat
);
  import phls_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVENT  = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_WAIT1  = 7'b0100000,
    S_WAIT2  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   started, started_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_WAIT1) || (state == S_WAIT2);
  assign out_last  = (state == S_WAIT2) || ((state == S_WAIT1) && !started);
  assign hold_busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    started_next = started;
    cmd          = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        cmd.scan_start = 1'b1;
        started_next = 1'b0;
        state_next = S_EVENT;
      end
      S_EVENT: begin
        cmd.exec = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: state_next = stat.scan_can ? S_SCAN : S_EMIT;
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.take = 1'b1;
          started_next = 1'b1;
          state_next = S_EMIT;
        end else if (stat.scan_end) state_next = S_EMIT;
        else cmd.scan_step = 1'b1;
      end
      S_EMIT: begin
        cmd.emit_event = 1'b1;
        state_next = S_WAIT1;
      end
      S_WAIT1: if (out_ready) begin
        if (started) begin
          cmd.emit_start = 1'b1;
          state_next = S_WAIT2;
        end else state_next = S_IDLE;
      end
      S_WAIT2: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= started_next;
    end
  end

endmodule
